FILE: rtl/core/udr_pkg.sv
// Shared types and constants for the receive-record deframer.
package udr_pkg;

  localparam int unsigned HDR_BYTES = 8;

  localparam logic [15:0] MAX_LEN_RESET = 16'd2048;

  typedef enum logic [1:0] {
    RES_HEADER  = 2'd0,
    RES_PAYLOAD = 2'd1,
    RES_DROP    = 2'd2
  } result_type_t;

  typedef struct packed {
    result_type_t result_type;
    logic [31:0]  source_ip;
    logic [15:0]  source_port;
    logic [15:0]  payload_length;
    logic         accepted;
    logic [7:0]   payload_byte;
    logic         last;
    logic [15:0]  read_pointer;
  } udr_result_t;

endpackage

FILE: rtl/core/udr_byte_if.sv
// Byte channel carrying ring bytes into the deframer.
interface udr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ring_byte;

  modport source (output valid, output ring_byte, input ready);
  modport sink (input valid, input ring_byte, output ready);
endinterface

FILE: rtl/core/udr_result_if.sv
// Result channel carrying header, payload and drop results out of the deframer.
interface udr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_type;
  logic [31:0] source_ip;
  logic [15:0] source_port;
  logic [15:0] payload_length;
  logic        accepted;
  logic [7:0]  payload_byte;
  logic        last;
  logic [15:0] read_pointer;

  modport source (
    output valid, output result_type, output source_ip, output source_port,
    output payload_length, output accepted, output payload_byte, output last,
    output read_pointer, input ready
  );
  modport sink (
    input valid, input result_type, input source_ip, input source_port,
    input payload_length, input accepted, input payload_byte, input last,
    input read_pointer, output ready
  );
endinterface

FILE: rtl/core/udr_parser.sv
// Record parser: header collection, accept decision, payload count and read pointer.
module udr_parser
  import udr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  ring_byte,
  input  logic [15:0] max_len,
  output logic        res_valid,
  output udr_result_t res
);

  logic [63:0] header_store;
  logic [3:0]  header_count;
  logic        in_payload;
  logic        keep_payload;
  logic [15:0] remaining_bytes;
  logic [15:0] ring_read_pointer;

  logic [63:0] header_store_next;
  logic [3:0]  header_count_next;
  logic        in_payload_next;
  logic        keep_payload_next;
  logic [15:0] remaining_bytes_next;
  logic [15:0] ring_read_pointer_next;

  logic [63:0] hdr_shift;
  logic [3:0]  count_inc;
  logic [15:0] rem_dec;
  logic [15:0] ptr_adv;
  logic        res_last;
  result_type_t res_type;

  assign hdr_shift = {header_store[55:0], ring_byte};
  assign count_inc = header_count + 4'd1;
  assign rem_dec   = remaining_bytes - 16'd1;
  // header path uses the freshly shifted length, payload path the stored one
  assign ptr_adv   = ring_read_pointer + 16'(HDR_BYTES)
                   + (in_payload ? header_store[15:0] : hdr_shift[15:0]);

  // Work out the next state and the result for the byte on offer
  always_comb begin
    header_store_next      = header_store;
    header_count_next      = header_count;
    in_payload_next        = in_payload;
    keep_payload_next      = keep_payload;
    remaining_bytes_next   = remaining_bytes;
    ring_read_pointer_next = ring_read_pointer;
    res_valid              = 1'b0;
    res_last               = 1'b0;
    res_type               = RES_HEADER;
    if (!in_payload) begin
      header_store_next = hdr_shift;
      header_count_next = count_inc;
      if (count_inc == 4'(HDR_BYTES)) begin
        keep_payload_next    = hdr_shift[15:0] <= max_len;
        remaining_bytes_next = hdr_shift[15:0];
        header_count_next    = 4'd0;
        res_valid            = 1'b1;
        if (hdr_shift[15:0] == 16'd0) begin
          // empty record closes on its header
          ring_read_pointer_next = ptr_adv;
          res_last               = 1'b1;
        end else begin
          in_payload_next = 1'b1;
        end
      end
    end else begin
      remaining_bytes_next = rem_dec;
      if (rem_dec == 16'd0) begin
        ring_read_pointer_next = ptr_adv;
        in_payload_next        = 1'b0;
        header_count_next      = 4'd0;
        res_valid              = 1'b1;
        res_last               = 1'b1;
        res_type               = keep_payload ? RES_PAYLOAD : RES_DROP;
      end else if (keep_payload) begin
        res_valid = 1'b1;
        res_type  = RES_PAYLOAD;
      end
    end
  end

  // Assemble the result from the updated header and pointer
  always_comb begin
    res.result_type    = res_type;
    res.source_ip      = header_store_next[63:32];
    res.source_port    = header_store_next[31:16];
    res.payload_length = header_store_next[15:0];
    res.accepted       = keep_payload_next;
    res.payload_byte   = (res_type == RES_PAYLOAD) ? ring_byte : 8'd0;
    res.last           = res_last;
    res.read_pointer   = res_last ? ring_read_pointer_next : 16'd0;
  end

  // Advance the record state on each byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      header_store      <= '0;
      header_count      <= '0;
      in_payload        <= 1'b0;
      keep_payload      <= 1'b0;
      remaining_bytes   <= '0;
      ring_read_pointer <= '0;
    end else if (step) begin
      header_store      <= header_store_next;
      header_count      <= header_count_next;
      in_payload        <= in_payload_next;
      keep_payload      <= keep_payload_next;
      remaining_bytes   <= remaining_bytes_next;
      ring_read_pointer <= ring_read_pointer_next;
    end
  end

  a_count_below_header: assert property (@(posedge clk) disable iff (rst)
    header_count < 4'(HDR_BYTES))
    else $error("header count reached a full header without closing");

  a_payload_count_clear: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (header_count == 4'd0 && remaining_bytes != 16'd0))
    else $error("payload phase with header count set or nothing left");

  a_last_closes_record: assert property (@(posedge clk) disable iff (rst)
    (step && res_valid && res.last) |=> !in_payload)
    else $error("record still open after its last result");

  a_pointer_moves_on_close: assert property (@(posedge clk) disable iff (rst)
    (step && !(res_valid && res.last)) |=> $stable(ring_read_pointer))
    else $error("read pointer moved without a record closing");

endmodule

FILE: rtl/core/udr_out_reg.sv
// Result register between the parser and the result channel.
module udr_out_reg
  import udr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  udr_result_t  res,
  output logic         space,
  udr_result_if.source out_ch
);

  logic        valid;
  udr_result_t data;

  // accept a new result when the register is empty or the held one is being taken
  assign space = !valid || out_ch.ready;

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign out_ch.valid          = valid;
  assign out_ch.result_type    = data.result_type;
  assign out_ch.source_ip      = data.source_ip;
  assign out_ch.source_port    = data.source_port;
  assign out_ch.payload_length = data.payload_length;
  assign out_ch.accepted       = data.accepted;
  assign out_ch.payload_byte   = data.payload_byte;
  assign out_ch.last           = data.last;
  assign out_ch.read_pointer   = data.read_pointer;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> space)
    else $error("result loaded over one not yet taken");

endmodule

FILE: rtl/core/udr_rx_record_deframer.sv
// Receive-record deframer: ring bytes in, header, payload and drop results out.
//
// ring_in takes one ring byte per transfer. Each record is an 8-byte
// big-endian header (source IP, source port, payload length) and its payload.
// result_out gives a header result after the eighth header byte, one result
// per payload byte of an accepted record, and one drop result at the end of
// a record whose length exceeds max_payload_length. The final result of a
// record carries last and the advanced read pointer.
// Throughput is one byte per cycle while result_out is not stalled; a result
// appears in the cycle after its byte, held in the single result register.
// When the receiver stalls, ring_in ready drops for as long as a result waits
// in the result register and result_out ready is low, whether or not the
// next byte would give a result; it rises again in the cycle the result goes.
// Reset clears the parser to expect a header, zeroes the read pointer, empties
// the result register and sets max_payload_length to 2048.
// Write cfg_wr_data with cfg_wr_en high to set max_payload_length; the
// accept decision is made at each header and held for that record.
module udp_rx_record_deframer
  import udr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  udr_byte_if.sink     ring_in,
  udr_result_if.source result_out
);

  logic [15:0] max_payload_length;
  logic        step;
  logic        res_valid;
  logic        space;
  udr_result_t res;

  // Hold the length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_payload_length <= cfg_wr_data;
    end
  end

  assign ring_in.ready = space;
  assign step          = ring_in.valid && space;

  udr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .ring_byte (ring_in.ring_byte),
    .max_len   (max_payload_length),
    .res_valid (res_valid),
    .res       (res)
  );

  udr_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (step && res_valid),
    .res    (res),
    .space  (space),
    .out_ch (result_out)
  );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the receive-record deframer: random records, stalls and limits.
module testbench;
  import udr_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_BYTES = 1400;
  localparam int SETTLE_GAP   = 4;

  // Track parser state, predict results and compare them as they arrive
  class record_scoreboard;
    logic [15:0]  max_len;
    logic [63:0]  hdr_shift;
    logic [3:0]   hdr_seen;
    bit           in_body;
    bit           keep_body;
    logic [15:0]  body_left;
    logic [15:0]  rd_ptr;
    udr_result_t  due_results[$];
    int           errors;
    int           header_count;
    int           payload_count;
    int           drop_count;

    function new();
      max_len   = MAX_LEN_RESET;
      hdr_shift = '0;
      hdr_seen  = '0;
      in_body   = 1'b0;
      keep_body = 1'b0;
      body_left = '0;
      rd_ptr    = '0;
      errors    = 0;
    endfunction

    function void set_max_len(logic [15:0] value);
      max_len = value;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Build one result from the current header and pointer
    function void push_result(result_type_t kind, logic [7:0] data, bit last);
      udr_result_t r;
      r.result_type    = kind;
      r.source_ip      = hdr_shift[63:32];
      r.source_port    = hdr_shift[31:16];
      r.payload_length = hdr_shift[15:0];
      r.accepted       = keep_body;
      r.payload_byte   = data;
      r.last           = last;
      r.read_pointer   = last ? rd_ptr : 16'd0;
      due_results.push_back(r);
    endfunction

    function void close_record();
      rd_ptr   = rd_ptr + 16'd8 + hdr_shift[15:0];
      in_body  = 1'b0;
      hdr_seen = '0;
    endfunction

    // Advance the parser by one accepted ring byte
    function void deframe_byte(logic [7:0] data);
      if (!in_body) begin
        hdr_shift = {hdr_shift[55:0], data};
        hdr_seen  = hdr_seen + 4'd1;
        if (hdr_seen < 4'd8) return;
        keep_body = hdr_shift[15:0] <= max_len;
        body_left = hdr_shift[15:0];
        if (body_left == 16'd0) begin
          close_record();
          push_result(RES_HEADER, 8'd0, 1'b1);
        end else begin
          in_body  = 1'b1;
          hdr_seen = '0;
          push_result(RES_HEADER, 8'd0, 1'b0);
        end
        return;
      end
      body_left = body_left - 16'd1;
      if (body_left == 16'd0) begin
        close_record();
        if (keep_body) push_result(RES_PAYLOAD, data, 1'b1);
        else push_result(RES_DROP, 8'd0, 1'b1);
      end else if (keep_body) begin
        push_result(RES_PAYLOAD, data, 1'b0);
      end
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Compare a received result with the oldest prediction
    task check_result(udr_result_t got);
      udr_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result of type %0d", got.result_type));
        return;
      end
      want = due_results.pop_front();
      check_field("result_type", 32'(got.result_type), 32'(want.result_type));
      check_field("source_ip", got.source_ip, want.source_ip);
      check_field("source_port", 32'(got.source_port), 32'(want.source_port));
      check_field("payload_length", 32'(got.payload_length), 32'(want.payload_length));
      check_field("accepted", 32'(got.accepted), 32'(want.accepted));
      check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
      check_field("last", 32'(got.last), 32'(want.last));
      check_field("read_pointer", 32'(got.read_pointer), 32'(want.read_pointer));
      case (want.result_type)
        RES_HEADER:  header_count++;
        RES_PAYLOAD: payload_count++;
        default:     drop_count++;
      endcase
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  int          idle_pct;
  int          cycle_count;
  int          bytes_sent;
  int          phase_count;
  logic [7:0]  ring_feed[$];
  logic [7:0]  byte_backlog[$];
  record_scoreboard sb;

  udr_byte_if   ring_if();
  udr_result_if res_if();

  udp_rx_record_deframer u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ring_in     (ring_if),
    .result_out  (res_if)
  );

  always #10 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Present the next ring byte once the current one has been taken
  always @(posedge clk) begin
    if (rst) begin
      ring_if.valid <= 1'b0;
    end else if (!ring_if.valid || ring_if.ready) begin
      if (ring_feed.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        ring_if.valid     <= 1'b1;
        ring_if.ring_byte <= ring_feed.pop_front();
      end else begin
        ring_if.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (rst) res_if.ready <= 1'b0;
    else res_if.ready <= $urandom_range(0, 99) >= idle_pct;
  end

  // Note every byte transfer
  always @(posedge clk) begin
    if (!rst && ring_if.valid && ring_if.ready) sb.deframe_byte(ring_if.ring_byte);
  end

  // Check every result transfer
  always @(posedge clk) begin : result_monitor
    udr_result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got = {res_if.result_type, res_if.source_ip, res_if.source_port,
             res_if.payload_length, res_if.accepted, res_if.payload_byte,
             res_if.last, res_if.read_pointer};
      sb.check_result(got);
    end
  end

  // Append one record to the backlog with a random payload
  task automatic queue_record(logic [31:0] ip, logic [15:0] port, logic [15:0] len);
    logic [63:0] hdr;
    hdr = {ip, port, len};
    for (int i = 7; i >= 0; i--) byte_backlog.push_back(hdr[i*8 +: 8]);
    for (int i = 0; i < len; i++) byte_backlog.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 24));
    if (r < 95) return 16'($urandom_range(25, 120));
    return 16'($urandom_range(121, 400));
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Move bytes from the backlog to the driver, making new records as needed
  task automatic feed(int count);
    @(negedge clk);
    for (int i = 0; i < count; i++) begin
      if (byte_backlog.size() == 0) queue_record(pick_word(), 16'(pick_word()), pick_length());
      ring_feed.push_back(byte_backlog.pop_front());
      bytes_sent++;
    end
  endtask

  // Wait until every byte is taken and every predicted result has arrived
  task automatic settle();
    while (ring_feed.size() != 0 || ring_if.valid) @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_max_len(logic [15:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_max_len(value);
    phase_count++;
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    idle_pct    = 31;
    cycle_count = 0;
    bytes_sent  = 0;
    phase_count = 0;
    ring_if.valid     = 1'b0;
    ring_if.ring_byte = '0;
    res_if.ready      = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset limit: empty record, all-ones header fields, short accepted payload
    queue_record(32'h0, 16'h0, 16'd0);
    queue_record(32'hFFFF_FFFF, 16'hFFFF, 16'd1);
    queue_record(32'h8000_0001, 16'h8001, 16'd2);
    feed(byte_backlog.size());
    settle();

    // Zero limit: empty record still accepted, any payload dropped
    write_max_len(16'd0);
    queue_record(32'h0A00_0001, 16'd53, 16'd0);
    queue_record(32'h0A00_0002, 16'd54, 16'd1);
    feed(byte_backlog.size());
    settle();

    // Length equal to the limit kept, one above dropped
    write_max_len(16'd5);
    queue_record(32'hC0A8_0101, 16'd1000, 16'd5);
    queue_record(32'hC0A8_0102, 16'd1001, 16'd6);
    feed(byte_backlog.size());
    settle();

    // Change the limit mid-payload: the decision taken at the header holds
    queue_record(32'h7F00_0001, 16'd4000, 16'd4);
    feed(10);
    settle();
    write_max_len(16'd0);
    feed(2);
    settle();

    // Change the limit mid-header: the new value decides
    queue_record(32'h7F00_0002, 16'd4001, 16'd3);
    feed(4);
    settle();
    write_max_len(16'd2);
    feed(byte_backlog.size());
    settle();

    // Random phases, each with its own limit; a phase may end inside a record
    while (bytes_sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 5))
        0:       write_max_len(16'd0);
        1:       write_max_len(16'hFFFF);
        2:       write_max_len(MAX_LEN_RESET);
        3:       write_max_len(16'($urandom_range(0, 30)));
        4:       write_max_len(16'($urandom_range(10, 130)));
        default: write_max_len(16'($urandom));
      endcase
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 31;
      feed($urandom_range(40, 220));
      settle();
    end

    // Close the open record, then one long accepted record with no idling
    write_max_len(16'hFFFF);
    idle_pct = 0;
    queue_record(pick_word(), 16'(pick_word()), 16'd100);
    feed(byte_backlog.size());
    settle();

    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Covered %0d ring bytes over %0d limit settings with random stalls on both sides",
             bytes_sent, phase_count);
    $display("Results: %0d headers, %0d payload bytes, %0d dropped records, %0d mismatches",
             sb.header_count, sb.payload_count, sb.drop_count, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
